FILE: rtl/core/acorn_pkg.sv
`timescale 1ns / 1ps

package acorn_pkg;

    localparam int STATE_W = 293;
    localparam int BYTE_W  = 8;
    // Working width: state plus room for the feedback byte beyond the top bit
    localparam int WORK_W  = 304;

    typedef logic [STATE_W-1:0] acorn_state_t;
    typedef logic [BYTE_W-1:0]  acorn_byte_t;

    typedef struct packed {
        acorn_state_t state;
        acorn_byte_t  dout;
    } acorn_result_t;

    function automatic acorn_byte_t maj8(input acorn_byte_t x, input acorn_byte_t y,
                                         input acorn_byte_t z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

    function automatic acorn_byte_t ch8(input acorn_byte_t x, input acorn_byte_t y,
                                        input acorn_byte_t z);
        return (x & y) ^ (~x & z);
    endfunction

    // Eight ACORN steps at once, step j on bit j of each byte-wide tap.
    function automatic acorn_result_t acorn_byte_step(input acorn_state_t st,
                                                      input logic enc,
                                                      input acorn_byte_t din,
                                                      input acorn_byte_t ca,
                                                      input acorn_byte_t cb);
        logic [WORK_W-1:0] s;
        acorn_byte_t t12, t235, t244, t23, t160, t111, t66, t196;
        acorn_byte_t t230, t193, t154, t107, t61, t0, t;
        acorn_byte_t ks, dout, pt, f;
        acorn_result_t res;
        s    = {{(WORK_W-STATE_W){1'b0}}, st};
        t12  = s[12 +: 8];  t235 = s[235 +: 8]; t244 = s[244 +: 8];
        t23  = s[23 +: 8];  t160 = s[160 +: 8]; t111 = s[111 +: 8];
        t66  = s[66 +: 8];  t196 = s[196 +: 8]; t230 = s[230 +: 8];
        t193 = s[193 +: 8]; t154 = s[154 +: 8]; t107 = s[107 +: 8];
        t61  = s[61 +: 8];  t0   = s[0 +: 8];

        // linear feedback corrections
        t = t235 ^ t230; s[289 +: 8] = s[289 +: 8] ^ t;
        t = t196 ^ t193; t230 = t230 ^ t; s[230 +: 8] = s[230 +: 8] ^ t;
        t = t160 ^ t154; t193 = t193 ^ t; s[193 +: 8] = s[193 +: 8] ^ t;
        t = t111 ^ t107; t154 = t154 ^ t; s[154 +: 8] = s[154 +: 8] ^ t;
        t = t66 ^ t61;   t107 = t107 ^ t; s[107 +: 8] = s[107 +: 8] ^ t;
        t = t23 ^ t0;    t61  = t61 ^ t;  s[61 +: 8]  = s[61 +: 8] ^ t;

        ks   = t12 ^ t154 ^ maj8(t235, t61, t193) ^ ch8(t230, t111, t66);
        dout = din ^ ks;
        pt   = enc ? din : dout;

        f = t0 ^ ~t107 ^ maj8(t244, t23, t160) ^ (ca & t196) ^ (cb & ks) ^ pt;
        s[293 +: 8] = s[293 +: 8] ^ f;

        // shift by eight; anything above the top bit drops out
        res.state = s[STATE_W+BYTE_W-1:BYTE_W];
        res.dout  = dout;
        return res;
    endfunction

endpackage

FILE: rtl/core/acorn128_byte_state_update.sv
`timescale 1ns / 1ps
// An input transaction reaches the result through the input register, then the result register.
// Throughput: one byte per cycle while out_stall is low; the 293-bit state feeds back through one pass of
// eight unrolled bit-steps, so each byte sees the state left by the one before.
// Reset (rst_n low, asynchronous): state cleared to zero, both stages emptied.
// A byte with restart set processes from an all-zero state.
module acorn128_byte_state_update
    import acorn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  acorn_byte_t data_in,
    input  acorn_byte_t ca_mask,
    input  acorn_byte_t cb_mask,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output acorn_byte_t data_out
);

    // Input stage: holds one accepted transaction until the result stage can take it
    logic          in_valid_reg;
    logic          kind_reg;
    acorn_byte_t   data_reg;
    acorn_byte_t   ca_reg;
    acorn_byte_t   cb_reg;
    logic          restart_reg;

    // Result stage
    logic          out_valid_reg;
    acorn_byte_t   dout_reg;

    // Cipher register, advanced once per byte as it moves into the result stage
    acorn_state_t  state_reg;
    acorn_state_t  state_next;
    acorn_state_t  state_src;
    acorn_result_t step;

    logic          out_free;
    logic          advance;
    logic          in_take;

    // Result stage is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    // Input stage takes a new transaction when empty or when it hands its byte on
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Restart clears the register before this byte is worked
    assign state_src  = restart_reg ? '0 : state_reg;
    assign step       = acorn_byte_step(state_src, kind_reg, data_reg, ca_reg, cb_reg);
    assign state_next = step.state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            // Hold the input stage while blocked, refill or drop otherwise
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // Advance the cipher only when a byte really moves on
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg    <= kind;
            data_reg    <= data_in;
            ca_reg      <= ca_mask;
            cb_reg      <= cb_mask;
            restart_reg <= restart;
        end
        if (advance)
        begin
            dout_reg <= step.dout;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = dout_reg;

    // The cipher register moves only with a byte passing into the result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("cipher state changed without a byte advancing");

    // A new result appears only after the input stage handed one on
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance && !out_valid_reg |=> !out_valid_reg)
        else $error("result appeared with no byte advancing");

    // Upstream is held back only when both stages are full and the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while a stage was free");

    // A full input stage facing a free result stage must hand its byte on
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("byte stuck in input stage");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import acorn_pkg::*;

    // Length of the run in input transactions, directed rows included
    localparam int TOTAL_BYTES = 1450;
    localparam int DIR_ROWS    = 20;
    // Long receiver hold-off: start once this many bytes are in, hold this many cycles
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    // Sender drains the pipe once, somewhere in the random part
    localparam int DRAIN_AT    = 900;
    localparam int REPORT_MAX  = 10;

    localparam logic        KIND_DECRYPT = 1'b0;
    localparam logic        KIND_ENCRYPT = 1'b1;
    localparam acorn_byte_t MASK_ON      = 8'hFF;
    localparam acorn_byte_t MASK_OFF     = 8'h00;

    // One directed transaction; 'typed' marks a row whose result is written in by hand
    typedef struct packed {
        logic        kind;
        acorn_byte_t din;
        acorn_byte_t ca;
        acorn_byte_t cb;
        logic        restart;
        logic        typed;
        acorn_byte_t want;
    } byte_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        kind      = KIND_ENCRYPT;
    acorn_byte_t data_in   = '0;
    acorn_byte_t ca_mask   = '0;
    acorn_byte_t cb_mask   = '0;
    logic        restart   = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    acorn_byte_t data_out;

    // Shadow copy of the 293-bit cipher register, advanced once per accepted byte
    acorn_state_t shadow_reg = '0;
    // Output bytes still owed by the block, oldest first
    acorn_byte_t  pending_out[$];
    acorn_byte_t  head_byte;
    int           fail_count = 0;
    int           bytes_sent = 0;

    acorn128_byte_state_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_in   (data_in),
        .ca_mask   (ca_mask),
        .cb_mask   (cb_mask),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every byte after a long gap and a long stall)
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Advance the shadow register by one byte (eight cipher steps) and return the
    // keystream-masked byte. Taps are read as byte-wide windows of the register,
    // bit j of each window belonging to step j.
    task automatic advance_shadow(input logic enc, input acorn_byte_t din,
                                  input acorn_byte_t ca, input acorn_byte_t cb,
                                  input logic clr, output acorn_byte_t dout);
        logic [303:0] w;
        acorn_byte_t  k0, k12, k23, k61, k66, k107, k111, k154, k160;
        acorn_byte_t  k193, k196, k230, k235, k244;
        acorn_byte_t  fix, ks, fb, pt, mj_ks, mj_fb, chs;
        if (clr)
            shadow_reg = '0;
        w    = {11'b0, shadow_reg};
        k0   = w[0 +: 8];   k12  = w[12 +: 8];  k23  = w[23 +: 8];
        k61  = w[61 +: 8];  k66  = w[66 +: 8];  k107 = w[107 +: 8];
        k111 = w[111 +: 8]; k154 = w[154 +: 8]; k160 = w[160 +: 8];
        k193 = w[193 +: 8]; k196 = w[196 +: 8]; k230 = w[230 +: 8];
        k235 = w[235 +: 8]; k244 = w[244 +: 8];

        // Six linear corrections, top LFSR first; each corrected tap is also
        // seen by the keystream and feedback below
        fix = k235 ^ k230;                  w[289 +: 8] ^= fix;
        fix = k196 ^ k193; k230 ^= fix;     w[230 +: 8] ^= fix;
        fix = k160 ^ k154; k193 ^= fix;     w[193 +: 8] ^= fix;
        fix = k111 ^ k107; k154 ^= fix;     w[154 +: 8] ^= fix;
        fix = k66 ^ k61;   k107 ^= fix;     w[107 +: 8] ^= fix;
        fix = k23 ^ k0;    k61 ^= fix;      w[61 +: 8]  ^= fix;

        mj_ks = (k235 & k61) | (k235 & k193) | (k61 & k193);
        chs   = (k230 & k111) | (~k230 & k66);
        ks    = k12 ^ k154 ^ mj_ks ^ chs;
        dout  = din ^ ks;
        // Decrypting feeds the recovered plaintext back, not the ciphertext
        pt    = (enc == KIND_ENCRYPT) ? din : dout;

        mj_fb = (k244 & k23) | (k244 & k160) | (k23 & k160);
        fb    = k0 ^ ~k107 ^ mj_fb ^ (ca & k196) ^ (cb & ks) ^ pt;
        w[293 +: 8] ^= fb;
        // Shift by a whole byte; anything above bit 300 drops out
        shadow_reg = w[300:8];
    endtask

    // Mostly short stretches, now and then a long one
    function automatic int pick_stretch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte, hold it until the block takes it, then log the byte it owes.
    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic offer_byte(input logic k, input acorn_byte_t d, input acorn_byte_t a,
                              input acorn_byte_t b, input logic clr, input logic typed,
                              input acorn_byte_t want);
        acorn_byte_t predicted;
        int gap;
        // Back-to-back windows keep stretches with no idling in the mix
        if (((bytes_sent / 128) % 4) == 2 || $urandom_range(0, 99) < 55)
            gap = 0;
        else
            gap = pick_stretch();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        data_in  <= d;
        ca_mask  <= a;
        cb_mask  <= b;
        restart  <= clr;
        do
            @(posedge clk);
        while (in_stall);
        advance_shadow(k, d, a, b, clr, predicted);
        pending_out.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    // Drop valid and wait for every owed byte to come back
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, quiet windows, and one long hold-off while the
    // sender keeps offering, so the block backs up and stalls its input
    initial
    begin : sink
        int  hold;
        int  cyc;
        bit  held_long;
        hold      = 0;
        cyc       = 0;
        held_long = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held_long && bytes_sent >= HOLD_AT)
            begin
                held_long = 1'b1;
                hold      = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (((cyc / 256) % 4) == 3 || $urandom_range(0, 99) < 70)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                hold      = pick_stretch() - 1;
            end
        end
    end

    // Compare every accepted output transaction with the oldest owed byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: unexpected output data_out=%02h", $realtime, data_out);
            end
            else
            begin
                head_byte = pending_out.pop_front();
                if (data_out !== head_byte)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: data_out mismatch: expected %02h, got %02h",
                                 $realtime, head_byte, data_out);
                end
            end
        end
    end

    initial
    begin : source
        byte_row_t   rows[DIR_ROWS];
        int          seg_len;
        int          j;
        int          r;
        logic        seg_kind;
        acorn_byte_t seg_ca;
        acorn_byte_t seg_cb;
        logic        seg_clear;
        logic        k;
        logic        clr;
        acorn_byte_t a;
        acorn_byte_t b;
        acorn_byte_t d;
        bit          drained;

        // Directed rows. A zero register gives a zero keystream, so the first byte
        // after reset and every byte with restart set comes back unchanged.
        //            kind          din    ca        cb        rst   typed want
        rows[0]  = '{KIND_ENCRYPT, 8'h00, MASK_ON,  MASK_ON,  1'b0, 1'b1, 8'h00};
        rows[1]  = '{KIND_ENCRYPT, 8'hFF, MASK_ON,  MASK_OFF, 1'b0, 1'b0, 8'h00};
        rows[2]  = '{KIND_DECRYPT, 8'h00, MASK_OFF, MASK_ON,  1'b0, 1'b0, 8'h00};
        rows[3]  = '{KIND_DECRYPT, 8'hFF, MASK_OFF, MASK_OFF, 1'b0, 1'b0, 8'h00};
        // masks that are neither all-ones nor all-zeros: each bit gates its own step
        rows[4]  = '{KIND_ENCRYPT, 8'h55, 8'hA5,    8'h5A,    1'b0, 1'b0, 8'h00};
        // restart in the middle of a stream, both directions
        rows[5]  = '{KIND_ENCRYPT, 8'hFF, MASK_ON,  MASK_ON,  1'b1, 1'b1, 8'hFF};
        rows[6]  = '{KIND_DECRYPT, 8'hA5, MASK_ON,  MASK_ON,  1'b1, 1'b1, 8'hA5};
        rows[7]  = '{KIND_DECRYPT, 8'h80, 8'h0F,    8'hF0,    1'b0, 1'b0, 8'h00};
        rows[8]  = '{KIND_ENCRYPT, 8'h01, 8'h01,    8'h80,    1'b0, 1'b0, 8'h00};
        rows[9]  = '{KIND_ENCRYPT, 8'hAA, MASK_ON,  MASK_ON,  1'b0, 1'b0, 8'h00};
        rows[10] = '{KIND_DECRYPT, 8'h55, MASK_ON,  MASK_ON,  1'b0, 1'b0, 8'h00};
        rows[11] = '{KIND_ENCRYPT, 8'h00, MASK_OFF, MASK_OFF, 1'b1, 1'b1, 8'h00};
        rows[12] = '{KIND_DECRYPT, 8'hFF, MASK_ON,  MASK_OFF, 1'b0, 1'b0, 8'h00};
        rows[13] = '{KIND_ENCRYPT, 8'h7F, MASK_OFF, MASK_ON,  1'b0, 1'b0, 8'h00};
        rows[14] = '{KIND_DECRYPT, 8'h3C, 8'h3C,    8'hC3,    1'b0, 1'b0, 8'h00};
        rows[15] = '{KIND_ENCRYPT, 8'hFF, MASK_ON,  MASK_ON,  1'b0, 1'b0, 8'h00};
        rows[16] = '{KIND_DECRYPT, 8'h00, MASK_OFF, MASK_OFF, 1'b0, 1'b0, 8'h00};
        rows[17] = '{KIND_DECRYPT, 8'h5A, 8'h55,    8'hAA,    1'b1, 1'b1, 8'h5A};
        rows[18] = '{KIND_ENCRYPT, 8'hC3, MASK_ON,  MASK_OFF, 1'b0, 1'b0, 8'h00};
        rows[19] = '{KIND_DECRYPT, 8'h96, MASK_OFF, MASK_ON,  1'b0, 1'b0, 8'h00};

        // Hold reset, then release it on an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (j = 0; j < DIR_ROWS; j++)
            offer_byte(rows[j].kind, rows[j].din, rows[j].ca, rows[j].cb,
                       rows[j].restart, rows[j].typed, rows[j].want);
        drain_pipe();

        // Random part: mostly well-formed messages (restart, then a run of bytes in
        // one direction and one cipher phase), the rest broken runs and noise
        drained = 1'b0;
        while (bytes_sent < TOTAL_BYTES)
        begin
            seg_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                    : $urandom_range(8, 64);
            seg_kind  = $urandom_range(0, 1) ? KIND_ENCRYPT : KIND_DECRYPT;
            seg_ca    = $urandom_range(0, 1) ? MASK_ON : MASK_OFF;
            seg_cb    = $urandom_range(0, 1) ? MASK_ON : MASK_OFF;
            // a run without a leading restart carries on from whatever went before
            seg_clear = ($urandom_range(0, 9) < 8);
            for (j = 0; j < seg_len && bytes_sent < TOTAL_BYTES; j++)
            begin
                k   = seg_kind;
                a   = seg_ca;
                b   = seg_cb;
                r   = $urandom_range(0, 99);
                if (r < 5)
                    k = ~seg_kind;
                else if (r < 12)
                begin
                    a = 8'($urandom_range(0, 255));
                    b = 8'($urandom_range(0, 255));
                end
                clr = (j == 0) ? seg_clear : ($urandom_range(0, 199) == 0);
                d   = 8'($urandom_range(0, 255));
                offer_byte(k, d, a, b, clr, 1'b0, 8'h00);
            end
            if (!drained && bytes_sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                drain_pipe();
            end
        end

        // Wind down: wait for every owed byte, then watch for strays
        drain_pipe();
        repeat (10) @(posedge clk);
        if (pending_out.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
